// File: hdl/modular_exponentiation_defines.svh
// ----------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Shared assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MEXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Sequencer states and the status bundle of the shared modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_RED_WAIT,
		ST_STEP,
		ST_SQ_WAIT,
		ST_MUL_WAIT,
		ST_FINISH
	} mexp_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mexp_mul_stat_t;

endpackage

// File: hdl/mexp_in_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation request channel
// Valid/ready channel carrying base, exponent and modulus.
// ----------------------------------------------------------------------------
interface mexp_in_if #(
	parameter int unsigned OPERAND_BITS = 31
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] base;
	logic [OPERAND_BITS-1:0] exponent;
	logic [OPERAND_BITS-1:0] modulus;

	modport source (output valid, output base, output exponent, output modulus, input ready);
	modport sink (input valid, input base, input exponent, input modulus, output ready);
endinterface

// File: hdl/mexp_out_if.sv
// ----------------------------------------------------------------------------
// Modular exponentiation response channel
// Valid/ready channel carrying the power result and the bad modulus flag.
// ----------------------------------------------------------------------------
interface mexp_out_if #(
	parameter int unsigned OPERAND_BITS = 31
);
	logic                    valid;
	logic                    ready;
	logic [OPERAND_BITS-1:0] power_result;
	logic                    bad_modulus;

	modport source (output valid, output power_result, output bad_modulus, input ready);
	modport sink (input valid, input power_result, input bad_modulus, output ready);
endinterface

// File: hdl/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Modular exponentiation serial modular multiplier
// Double-and-add a * b mod m, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module mexp_mulmod
	import mexp_pkg::*;
#(
	parameter int unsigned OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] a,
	input  logic [OPERAND_BITS-1:0] b,
	input  logic [OPERAND_BITS-1:0] m,
	output logic [OPERAND_BITS-1:0] r,
	output mexp_mul_stat_t          stat
);

	localparam int unsigned W  = OPERAND_BITS;
	localparam int unsigned CW = $clog2(W);
	localparam int unsigned TW = W + 2;

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [TW-1:0] sum;
	logic [TW-1:0] m1;
	logic [TW-1:0] m2;
	logic [TW-1:0] red;

	assign m1  = {2'b00, m};
	assign m2  = {1'b0, m, 1'b0};
	assign sum = {1'b0, r_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);

	always_comb begin
		if (sum >= m2) begin
			red = sum - m2;
		end else if (sum >= m1) begin
			red = sum - m1;
		end else begin
			red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= red[W-1:0];
			b_q <= b_q << 1;
		end
	end

	assign r         = r_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	`MEXP_ASSERT(a_done_pulse, done_q |=> !done_q, "multiplier done held for two cycles")
	`MEXP_ASSERT_ALWAYS(a_done_reduced, done_q |-> (r_q < m), "multiplier result not reduced")

endmodule

// File: hdl/mexp_ctrl.sv
// ----------------------------------------------------------------------------
// Modular exponentiation sequencer
// Scans the exponent MSB first and issues square and multiply operations.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_defines.svh"

module mexp_ctrl
	import mexp_pkg::*;
#(
	parameter int unsigned OPERAND_BITS = 31
) (
	input  logic                    clk,
	input  logic                    arst_n,
	mexp_in_if.sink                 req,
	mexp_out_if.source              rsp,
	output logic                    mul_start,
	output logic [OPERAND_BITS-1:0] mul_a,
	output logic [OPERAND_BITS-1:0] mul_b,
	output logic [OPERAND_BITS-1:0] mul_m,
	input  logic [OPERAND_BITS-1:0] mul_r,
	input  mexp_mul_stat_t          mul_stat
);

	localparam int unsigned W  = OPERAND_BITS;
	localparam int unsigned CW = $clog2(W);

	mexp_state_t state_q;
	mexp_state_t state_d;

	logic [W-1:0]  base_q;
	logic [W-1:0]  exp_q;
	logic [W-1:0]  mod_q;
	logic [W-1:0]  y_q;
	logic          bad_q;
	logic [CW-1:0] cnt_q;

	logic [W-1:0]  res_q;
	logic          res_bad_q;
	logic          out_valid_q;

	logic          accept;
	logic          load_out;

	assign accept   = req.valid && req.ready;
	assign load_out = (state_q == ST_FINISH) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.modulus == '0 || req.exponent == '0) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_ALIGN;
					end
				end
			end
			ST_ALIGN: begin
				if (exp_q[W-1]) begin
					state_d = ST_RED_WAIT;
				end
			end
			ST_RED_WAIT: begin
				if (mul_stat.done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_SQ_WAIT;
				end
			end
			ST_SQ_WAIT: begin
				if (mul_stat.done) begin
					state_d = exp_q[W-1] ? ST_MUL_WAIT : ST_STEP;
				end
			end
			ST_MUL_WAIT: begin
				if (mul_stat.done) begin
					state_d = ST_STEP;
				end
			end
			ST_FINISH: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = y_q;
		mul_b     = y_q;
		req.ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_ALIGN: begin
				mul_start = exp_q[W-1];
				mul_a     = W'(1);
				mul_b     = base_q;
			end
			ST_STEP: begin
				mul_start = (cnt_q != '0);
			end
			ST_SQ_WAIT: begin
				mul_start = mul_stat.done && exp_q[W-1];
				mul_a     = mul_r;
				mul_b     = base_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	assign mul_m = mod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					base_q <= req.base;
					exp_q  <= req.exponent;
					mod_q  <= req.modulus;
					cnt_q  <= CW'(W - 1);
					bad_q  <= (req.modulus == '0);
					if (req.modulus == '0 || req.modulus == W'(1)) begin
						y_q <= '0;
					end else begin
						y_q <= W'(1);
					end
				end
			end
			ST_ALIGN: begin
				exp_q <= exp_q << 1;
				if (!exp_q[W-1]) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
			ST_RED_WAIT: begin
				if (mul_stat.done) begin
					base_q <= mul_r;
					y_q    <= mul_r;
				end
			end
			ST_SQ_WAIT: begin
				if (mul_stat.done) begin
					y_q <= mul_r;
					if (!exp_q[W-1]) begin
						exp_q <= exp_q << 1;
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
			ST_MUL_WAIT: begin
				if (mul_stat.done) begin
					y_q   <= mul_r;
					exp_q <= exp_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (load_out) begin
			res_q     <= y_q;
			res_bad_q <= bad_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.power_result = res_q;
	assign rsp.bad_modulus  = res_bad_q;

	`MEXP_ASSERT(a_start_free, mul_start |-> !mul_stat.busy, "multiplier started while busy")
	`MEXP_ASSERT(a_bad_zero, (out_valid_q && res_bad_q) |-> (res_q == '0), "bad modulus gave nonzero result")
	`MEXP_ASSERT(a_step_reduced, (state_q == ST_STEP) |-> (y_q < mod_q), "running value not reduced")

endmodule

// File: hdl/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Left-to-right square-and-multiply computation of base^exponent mod modulus.
// ----------------------------------------------------------------------------
// One transaction takes base, exponent and modulus and returns one result.
// All arithmetic runs through a single serial modular multiplier that
// handles one multiplier bit per cycle while busy. A transaction with a
// nonzero exponent and modulus first locates the top exponent bit, spends one
// product reducing the base, then for every lower exponent bit one square
// plus one multiply when that bit is set. A zero modulus or zero exponent
// goes straight to the finish state. The request side is ready only between
// transactions; a finished result waits in an output register while the
// next request is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int unsigned OPERAND_BITS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	mexp_in_if.sink    req,
	mexp_out_if.source rsp
);

	logic                    mul_start;
	logic [OPERAND_BITS-1:0] mul_a;
	logic [OPERAND_BITS-1:0] mul_b;
	logic [OPERAND_BITS-1:0] mul_m;
	logic [OPERAND_BITS-1:0] mul_r;
	mexp_mul_stat_t          mul_stat;

	mexp_ctrl #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mul_start(mul_start),
		.mul_a    (mul_a),
		.mul_b    (mul_b),
		.mul_m    (mul_m),
		.mul_r    (mul_r),
		.mul_stat (mul_stat)
	);

	mexp_mulmod #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_mulmod (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.m     (mul_m),
		.r     (mul_r),
		.stat  (mul_stat)
	);

endmodule

// File: sim/modular_exponentiation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// A directed table of edge cases is followed by random requests of mixed
// operand sizes. Each request is scored against a known table answer or by an
// independent power-mod calculator. Bursty requests and a patterned response stall are used.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;

	localparam int unsigned OB          = 31;
	localparam int unsigned N_DIRECTED  = 22;
	localparam int unsigned N_RANDOM    = 258;
	localparam int unsigned DRAIN       = 2200;
	localparam longint      CYCLE_LIMIT = 3_000_000;
	localparam logic [OB-1:0] FULL      = '1;

	typedef struct packed {
		logic [OB-1:0] base;
		logic [OB-1:0] exponent;
		logic [OB-1:0] modulus;
		bit            known;
		logic [OB-1:0] power;
		logic          bad;
	} stim_row_t;

	typedef struct packed {
		logic [OB-1:0] power;
		logic          bad;
	} power_answer_t;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_CHOKE
	} sink_mode_t;

	bit            clk;
	logic          arst_n;
	power_answer_t pending_powers [$];
	int            mismatches;
	int            burst_left;
	longint        cycles;

	mexp_in_if  #(.OPERAND_BITS(OB)) req ();
	mexp_out_if #(.OPERAND_BITS(OB)) rsp ();

	modular_exponentiation #(
		.OPERAND_BITS(OB)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	stim_row_t directed_rows [0:N_DIRECTED-1] = '{
		'{FULL, FULL, 31'd0, 1'b1, 31'd0, 1'b1},
		'{31'd0, 31'd0, 31'd0, 1'b1, 31'd0, 1'b1},
		'{31'd12345, 31'd0, 31'd1, 1'b1, 31'd0, 1'b0},
		'{FULL, 31'd0, FULL, 1'b1, 31'd1, 1'b0},
		'{31'd0, 31'd0, 31'd5, 1'b1, 31'd1, 1'b0},
		'{31'd0, 31'd5, 31'd7, 1'b1, 31'd0, 1'b0},
		'{FULL, 31'd1, FULL, 1'b1, 31'd0, 1'b0},
		'{31'd10, 31'd1, 31'd7, 1'b1, 31'd3, 1'b0},
		'{31'd1, FULL, FULL, 1'b1, 31'd1, 1'b0},
		'{FULL, FULL, FULL, 1'b1, 31'd0, 1'b0},
		'{FULL - 31'd1, FULL, FULL, 1'b1, FULL - 31'd1, 1'b0},
		'{31'd5, 31'd3, 31'd1, 1'b1, 31'd0, 1'b0},
		'{31'd2, 31'd10, 31'd2000, 1'b1, 31'd1024, 1'b0},
		'{31'd2, 31'd30, FULL, 1'b1, 31'h4000_0000, 1'b0},
		'{31'd3, 31'd4, 31'd100, 1'b1, 31'd81, 1'b0},
		'{FULL, FULL, 31'd2, 1'b1, 31'd1, 1'b0},
		'{31'd2, 31'd31, FULL, 1'b0, 31'd0, 1'b0},
		'{FULL, 31'd2, 31'h4000_0000, 1'b0, 31'd0, 1'b0},
		'{31'd3, 31'h4000_0000, FULL, 1'b0, 31'd0, 1'b0},
		'{31'd123456789, 31'd65537, 31'd2147483629, 1'b0, 31'd0, 1'b0},
		'{31'h2AAA_AAAA, 31'h5555_5555, 31'h7FFF_FFFE, 1'b0, 31'd0, 1'b0},
		'{31'h5555_5555, 31'h2AAA_AAAA, 31'h2AAA_AAAB, 1'b0, 31'd0, 1'b0}
	};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic power_answer_t predict_power(stim_row_t row);
		power_answer_t ans;
		bit [63:0]     m;
		bit [63:0]     b;
		bit [63:0]     acc;
		ans.bad   = (row.modulus == '0);
		ans.power = '0;
		if (!ans.bad) begin
			m   = 64'(row.modulus);
			b   = 64'(row.base) % m;
			acc = 64'd1 % m;
			for (int i = OB - 1; i >= 0; i--) begin
				acc = (acc * acc) % m;
				if (row.exponent[i])
					acc = (acc * b) % m;
			end
			ans.power = acc[OB-1:0];
		end
		return ans;
	endfunction

	function automatic logic [OB-1:0] random_bits(int unsigned width);
		logic [OB-1:0] mask;
		mask = (width >= OB) ? '1 : ((OB'(1) << width) - OB'(1));
		return OB'($urandom) & mask;
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t row;
		int        roll;
		row  = '0;
		roll = $urandom_range(0, 99);
		if (roll < 40) begin
			row.base     = OB'($urandom);
			row.exponent = OB'($urandom);
			row.modulus  = OB'($urandom);
		end else if (roll < 60) begin
			row.base     = OB'($urandom);
			row.exponent = random_bits($urandom_range(1, 12));
			row.modulus  = OB'($urandom_range(1, 255));
		end else if (roll < 70) begin
			row.base     = random_bits($urandom_range(1, OB));
			row.exponent = $urandom_range(0, 1) ? '0 : random_bits($urandom_range(1, OB));
			row.modulus  = OB'($urandom_range(0, 2));
		end else if (roll < 85) begin
			row.base     = OB'($urandom) | OB'(1 << (OB - 1));
			row.exponent = random_bits($urandom_range(1, OB));
			row.modulus  = random_bits($urandom_range(1, 16)) | OB'(1);
		end else begin
			row.base     = random_bits($urandom_range(1, OB));
			row.exponent = random_bits($urandom_range(1, OB));
			row.modulus  = random_bits($urandom_range(1, OB));
		end
		return row;
	endfunction

	// Hold each request until taken; gap only between bursts.
	task automatic offer(stim_row_t row);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid    <= 1'b1;
		req.base     <= row.base;
		req.exponent <= row.exponent;
		req.modulus  <= row.modulus;
		do @(posedge clk); while (!req.ready);
		if (row.known)
			pending_powers.push_back('{row.power, row.bad});
		else
			pending_powers.push_back(predict_power(row));
	endtask

	initial begin
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.base     <= '0;
		req.exponent <= '0;
		req.modulus  <= '0;
		mismatches   = 0;
		burst_left   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			offer(directed_rows[i]);
		for (int i = 0; i < N_RANDOM; i++)
			offer(random_row());
		req.valid <= 1'b0;
		wait (pending_powers.size() == 0);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		sink_mode_t mode;
		int         mode_left;
		int         hold;
		mode       = SINK_OPEN;
		mode_left  = 0;
		hold       = 0;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode      = sink_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(20, 300);
			end
			mode_left--;
			case (mode)
				SINK_OPEN: begin
					rsp.ready <= 1'b1;
				end
				SINK_COIN: begin
					rsp.ready <= 1'($urandom_range(0, 1));
				end
				default: begin
					if (hold == 0)
						hold = $urandom_range(2, 40);
					hold--;
					rsp.ready <= (hold == 0);
				end
			endcase
		end
	end

	always @(posedge clk) begin
		power_answer_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_powers.size() == 0) begin
				$error("unexpected transaction: power_result %0d bad_modulus %0d",
					rsp.power_result, rsp.bad_modulus);
				mismatches++;
			end else begin
				want = pending_powers.pop_front();
				if (rsp.power_result !== want.power) begin
					$error("power_result: expected %0d, actual %0d",
						want.power, rsp.power_result);
					mismatches++;
				end
				if (rsp.bad_modulus !== want.bad) begin
					$error("bad_modulus: expected %0d, actual %0d",
						want.bad, rsp.bad_modulus);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

endmodule

// File: files.f
+incdir+hdl
hdl/mexp_pkg.sv
hdl/mexp_in_if.sv
hdl/mexp_out_if.sv
hdl/mexp_mulmod.sv
hdl/mexp_ctrl.sv
hdl/modular_exponentiation.sv
sim/modular_exponentiation_tb.sv
